[rtl/cts_pkg.sv]
`timescale 1ns / 1ps

package cts_pkg;

	localparam int unsigned YEAR_W   = 7;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned SECOND_W = 6;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned KEY_W    = 3;
	localparam int unsigned SEL_W    = 3;
	localparam int unsigned PERIOD_W = 16;

	localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = 16'd500;

	localparam logic [YEAR_W-1:0]   YEAR_MAX   = 7'd99;
	localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;
	localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
	localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
	localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;
	localparam logic [YEAR_W-1:0]   YEAR_CENTURY = 7'd100;
	localparam logic [DAY_W-1:0]    FEB_LEAP_LEN = 5'd29;
	localparam logic [DAY_W-1:0]    LONG_MONTH   = 5'd31;

	typedef enum logic [KIND_W-1:0] {
		KIND_KEY  = 2'd0,
		KIND_TICK = 2'd1,
		KIND_SNAP = 2'd2
	} kind_t;

	typedef enum logic [KEY_W-1:0] {
		KEY_NONE   = 3'd0,
		KEY_MODE   = 3'd1,
		KEY_SELECT = 3'd2,
		KEY_UP     = 3'd3,
		KEY_DOWN   = 3'd4
	} key_t;

	typedef enum logic [SEL_W-1:0] {
		FIELD_YEAR   = 3'd0,
		FIELD_MONTH  = 3'd1,
		FIELD_DAY    = 3'd2,
		FIELD_HOUR   = 3'd3,
		FIELD_MINUTE = 3'd4,
		FIELD_SECOND = 3'd5
	} field_t;

	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0] yr,
			input logic [MONTH_W-1:0] mo);
		logic leap;
		logic [DAY_W-1:0] len;
		leap = (yr[1:0] == 2'b00) && (yr != YEAR_CENTURY);
		if (mo == 4'd0 || mo > MONTH_MAX) begin
			len = LONG_MONTH;
		end else if (mo == 4'd2 && leap) begin
			len = FEB_LEAP_LEN;
		end else begin
			len = MONTH_LEN[4'(mo - 4'd1)];
		end
		return len;
	endfunction

endpackage

[rtl/cts_if.sv]
`timescale 1ns / 1ps

interface cts_in_if;
	logic                          valid;
	logic                          ready;
	logic [cts_pkg::KIND_W-1:0]    kind;
	logic [cts_pkg::KEY_W-1:0]     key;
	logic [cts_pkg::YEAR_W-1:0]    snap_year;
	logic [cts_pkg::MONTH_W-1:0]   snap_month;
	logic [cts_pkg::DAY_W-1:0]     snap_day;
	logic [cts_pkg::HOUR_W-1:0]    snap_hour;
	logic [cts_pkg::MINUTE_W-1:0]  snap_minute;
	logic [cts_pkg::SECOND_W-1:0]  snap_second;

	modport source (output valid, kind, key, snap_year, snap_month, snap_day, snap_hour,
		snap_minute, snap_second, input ready);
	modport sink (input valid, kind, key, snap_year, snap_month, snap_day, snap_hour,
		snap_minute, snap_second, output ready);
endinterface

interface cts_out_if;
	logic                          valid;
	logic                          ready;
	logic                          set_mode;
	logic [cts_pkg::SEL_W-1:0]     selected_field;
	logic                          blink_on;
	logic                          commit;
	logic [cts_pkg::YEAR_W-1:0]    out_year;
	logic [cts_pkg::MONTH_W-1:0]   out_month;
	logic [cts_pkg::DAY_W-1:0]     out_day;
	logic [cts_pkg::HOUR_W-1:0]    out_hour;
	logic [cts_pkg::MINUTE_W-1:0]  out_minute;
	logic [cts_pkg::SECOND_W-1:0]  out_second;

	modport source (output valid, set_mode, selected_field, blink_on, commit, out_year,
		out_month, out_day, out_hour, out_minute, out_second, input ready);
	modport sink (input valid, set_mode, selected_field, blink_on, commit, out_year,
		out_month, out_day, out_hour, out_minute, out_second, output ready);
endinterface

[rtl/clock_time_setting_controller.sv]
// channel       dir  handshake       words
// item          in   valid/ready     kind, key, snap_year .. snap_second
// result        out  valid/ready     set_mode, selected_field, blink_on, commit, fields
// blink_period  in   write enable    16-bit tick count, no read-back
//
// one word per cycle sustained while the result is not stalled; an accepted item passes
// the input register, then the state update together with the result register, to result valid
// arst_n clears mode, selector, blink, tick count, year and time; month and day reset to 1
// a stalled result holds the state; the input register still takes one more word if it is empty
`timescale 1ns / 1ps

module clock_time_setting_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	cts_in_if.sink                          item,
	cts_out_if.source                       result,
	input  logic                            blink_period_we,
	input  logic [cts_pkg::PERIOD_W-1:0]    blink_period_wdata
);

	logic [cts_pkg::PERIOD_W-1:0] blink_period_q;

	logic                          valid_s1;
	logic [cts_pkg::KIND_W-1:0]    kind_s1;
	logic [cts_pkg::KEY_W-1:0]     key_s1;
	logic [cts_pkg::YEAR_W-1:0]    snap_year_s1;
	logic [cts_pkg::MONTH_W-1:0]   snap_month_s1;
	logic [cts_pkg::DAY_W-1:0]     snap_day_s1;
	logic [cts_pkg::HOUR_W-1:0]    snap_hour_s1;
	logic [cts_pkg::MINUTE_W-1:0]  snap_minute_s1;
	logic [cts_pkg::SECOND_W-1:0]  snap_second_s1;

	logic                          out_valid_q;
	logic                          commit_q;
	logic                          mode_q;
	logic [cts_pkg::SEL_W-1:0]     sel_q;
	logic                          blink_q;
	logic [cts_pkg::PERIOD_W-1:0]  tick_q;
	logic [cts_pkg::YEAR_W-1:0]    year_q;
	logic [cts_pkg::MONTH_W-1:0]   month_q;
	logic [cts_pkg::DAY_W-1:0]     day_q;
	logic [cts_pkg::HOUR_W-1:0]    hour_q;
	logic [cts_pkg::MINUTE_W-1:0]  minute_q;
	logic [cts_pkg::SECOND_W-1:0]  second_q;

	logic                          mode_d;
	logic [cts_pkg::SEL_W-1:0]     sel_d;
	logic                          blink_d;
	logic [cts_pkg::PERIOD_W-1:0]  tick_d;
	logic                          commit_d;
	logic [cts_pkg::YEAR_W-1:0]    year_d;
	logic [cts_pkg::MONTH_W-1:0]   month_d;
	logic [cts_pkg::DAY_W-1:0]     day_d;
	logic [cts_pkg::HOUR_W-1:0]    hour_d;
	logic [cts_pkg::MINUTE_W-1:0]  minute_d;
	logic [cts_pkg::SECOND_W-1:0]  second_d;

	// raise path, one bit wider to see the carry
	logic [cts_pkg::YEAR_W:0]      yr_inc;
	logic [cts_pkg::MONTH_W:0]     mo_inc;
	logic [cts_pkg::DAY_W:0]       dy_inc;
	logic [cts_pkg::HOUR_W:0]      hr_inc;
	logic [cts_pkg::MINUTE_W:0]    mi_inc;
	logic [cts_pkg::SECOND_W:0]    se_inc;
	logic [cts_pkg::YEAR_W-1:0]    yr_up;
	logic [cts_pkg::MONTH_W-1:0]   mo_up;
	logic [cts_pkg::DAY_W-1:0]     dy_up;
	logic [cts_pkg::HOUR_W-1:0]    hr_up;
	logic [cts_pkg::MINUTE_W-1:0]  mi_up;
	logic [cts_pkg::SECOND_W-1:0]  se_up;

	// lower path
	logic [cts_pkg::YEAR_W-1:0]    yr_dn;
	logic [cts_pkg::MONTH_W-1:0]   mo_dn;
	logic [cts_pkg::DAY_W-1:0]     dy_dn;
	logic [cts_pkg::HOUR_W-1:0]    hr_dn;
	logic [cts_pkg::MINUTE_W-1:0]  mi_dn;
	logic [cts_pkg::SECOND_W-1:0]  se_dn;

	logic [cts_pkg::PERIOD_W:0]    tick_inc;
	logic                          out_free;
	logic                          advance;

	assign out_free   = !out_valid_q || result.ready;
	assign advance    = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_period_q <= cts_pkg::BLINK_PERIOD_RST;
		end else if (blink_period_we) begin
			blink_period_q <= blink_period_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			kind_s1        <= item.kind;
			key_s1         <= item.key;
			snap_year_s1   <= item.snap_year;
			snap_month_s1  <= item.snap_month;
			snap_day_s1    <= item.snap_day;
			snap_hour_s1   <= item.snap_hour;
			snap_minute_s1 <= item.snap_minute;
			snap_second_s1 <= item.snap_second;
		end
	end

	always_comb begin
		yr_inc = {1'b0, year_q}   + ((sel_q == cts_pkg::FIELD_YEAR)   ? 8'd1 : 8'd0);
		mo_inc = {1'b0, month_q}  + ((sel_q == cts_pkg::FIELD_MONTH)  ? 5'd1 : 5'd0);
		dy_inc = {1'b0, day_q}    + ((sel_q == cts_pkg::FIELD_DAY)    ? 6'd1 : 6'd0);
		hr_inc = {1'b0, hour_q}   + ((sel_q == cts_pkg::FIELD_HOUR)   ? 6'd1 : 6'd0);
		mi_inc = {1'b0, minute_q} + ((sel_q == cts_pkg::FIELD_MINUTE) ? 7'd1 : 7'd0);
		se_inc = {1'b0, second_q} + ((sel_q == cts_pkg::FIELD_SECOND) ? 7'd1 : 7'd0);

		yr_up = (yr_inc > {1'b0, cts_pkg::YEAR_MAX})   ? '0   : yr_inc[cts_pkg::YEAR_W-1:0];
		mo_up = (mo_inc > {1'b0, cts_pkg::MONTH_MAX})  ? 4'd1 : mo_inc[cts_pkg::MONTH_W-1:0];
		dy_up = (dy_inc > {1'b0, cts_pkg::month_days(yr_up, mo_up)}) ? 5'd1
			: dy_inc[cts_pkg::DAY_W-1:0];
		hr_up = (hr_inc > {1'b0, cts_pkg::HOUR_MAX})   ? '0   : hr_inc[cts_pkg::HOUR_W-1:0];
		mi_up = (mi_inc > {1'b0, cts_pkg::MINUTE_MAX}) ? '0   : mi_inc[cts_pkg::MINUTE_W-1:0];
		se_up = (se_inc > {1'b0, cts_pkg::SECOND_MAX}) ? '0   : se_inc[cts_pkg::SECOND_W-1:0];

		// lower: below-range checks on month and day apply even when that field is not the selected one
		if (sel_q == cts_pkg::FIELD_YEAR) begin
			yr_dn = (year_q == '0) ? cts_pkg::YEAR_MAX : year_q - 7'd1;
		end else begin
			yr_dn = year_q;
		end
		if (sel_q == cts_pkg::FIELD_MONTH) begin
			mo_dn = (month_q <= 4'd1) ? cts_pkg::MONTH_MAX : month_q - 4'd1;
		end else begin
			mo_dn = (month_q == '0) ? cts_pkg::MONTH_MAX : month_q;
		end
		if (sel_q == cts_pkg::FIELD_DAY) begin
			dy_dn = (day_q <= 5'd1) ? cts_pkg::month_days(yr_dn, mo_dn) : day_q - 5'd1;
		end else begin
			dy_dn = (day_q == '0) ? cts_pkg::month_days(yr_dn, mo_dn) : day_q;
		end
		if (sel_q == cts_pkg::FIELD_HOUR) begin
			hr_dn = (hour_q == '0) ? cts_pkg::HOUR_MAX : hour_q - 5'd1;
		end else begin
			hr_dn = hour_q;
		end
		if (sel_q == cts_pkg::FIELD_MINUTE) begin
			mi_dn = (minute_q == '0) ? cts_pkg::MINUTE_MAX : minute_q - 6'd1;
		end else begin
			mi_dn = minute_q;
		end
		if (sel_q == cts_pkg::FIELD_SECOND) begin
			se_dn = (second_q == '0) ? cts_pkg::SECOND_MAX : second_q - 6'd1;
		end else begin
			se_dn = second_q;
		end

		tick_inc = {1'b0, tick_q} + 17'd1;

		mode_d   = mode_q;
		sel_d    = sel_q;
		blink_d  = blink_q;
		tick_d   = tick_q;
		commit_d = 1'b0;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;

		case (kind_s1)
			cts_pkg::KIND_KEY: begin
				if (key_s1 == cts_pkg::KEY_MODE) begin
					mode_d = !mode_q;
					if (!mode_q) begin
						sel_d = cts_pkg::FIELD_YEAR;
					end else begin
						commit_d = 1'b1;
					end
				end else if (mode_q) begin
					case (key_s1)
						cts_pkg::KEY_SELECT: begin
							sel_d = (sel_q == cts_pkg::FIELD_SECOND) ? cts_pkg::FIELD_YEAR
								: sel_q + 3'd1;
						end
						cts_pkg::KEY_UP: begin
							year_d   = yr_up;
							month_d  = mo_up;
							day_d    = dy_up;
							hour_d   = hr_up;
							minute_d = mi_up;
							second_d = se_up;
						end
						cts_pkg::KEY_DOWN: begin
							year_d   = yr_dn;
							month_d  = mo_dn;
							day_d    = dy_dn;
							hour_d   = hr_dn;
							minute_d = mi_dn;
							second_d = se_dn;
						end
						default: begin
						end
					endcase
				end
			end
			cts_pkg::KIND_TICK: begin
				if (tick_inc >= {1'b0, blink_period_q}) begin
					tick_d  = '0;
					blink_d = !blink_q;
				end else begin
					tick_d = tick_inc[cts_pkg::PERIOD_W-1:0];
				end
			end
			cts_pkg::KIND_SNAP: begin
				if (!mode_q) begin
					year_d   = snap_year_s1;
					month_d  = snap_month_s1;
					day_d    = snap_day_s1;
					hour_d   = snap_hour_s1;
					minute_d = snap_minute_s1;
					second_d = snap_second_s1;
				end
			end
			default: begin
			end
		endcase
	end

	// state doubles as the result register; it moves only when a word is handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			commit_q    <= 1'b0;
			mode_q      <= 1'b0;
			sel_q       <= cts_pkg::FIELD_YEAR;
			blink_q     <= 1'b0;
			tick_q      <= '0;
			year_q      <= '0;
			month_q     <= 4'd1;
			day_q       <= 5'd1;
			hour_q      <= '0;
			minute_q    <= '0;
			second_q    <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (advance) begin
				commit_q <= commit_d;
				mode_q   <= mode_d;
				sel_q    <= sel_d;
				blink_q  <= blink_d;
				tick_q   <= tick_d;
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.set_mode       = mode_q;
	assign result.selected_field = sel_q;
	assign result.blink_on       = blink_q;
	assign result.commit         = commit_q;
	assign result.out_year       = year_q;
	assign result.out_month      = month_q;
	assign result.out_day        = day_q;
	assign result.out_hour       = hour_q;
	assign result.out_minute     = minute_q;
	assign result.out_second     = second_q;

endmodule
